>>> rtl/bdh_pkg.sv
// Shared types and constants for the button debounce and hold detector.
package bdh_pkg;

  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W   = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD  = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_W-1:0] SHORT_HOLD_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] LONG_HOLD_RESET  = 16'd3000;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_PRESSED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LONG     = 2'd3;

  // bit positions in an event mask, in emission order
  localparam int EV_EDGE  = 0;
  localparam int EV_SHORT = 1;
  localparam int EV_LONG  = 2;
  localparam int EV_N     = 3;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [EV_N-1:0]   mask;
    logic              is_release;
    logic [TIME_W-1:0] stamp;
  } bdh_evset_t;

endpackage

>>> rtl/bdh_front.sv
// Debounce and hold front end: takes ticks, updates state, emits event sets.
module bdh_front
  import bdh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 pin_level,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic                 q_full,
  output logic                 push,
  output bdh_evset_t           push_data
);

  logic [CFG_W-1:0]  debounce_time;
  logic [CFG_W-1:0]  short_hold_time;
  logic [CFG_W-1:0]  long_hold_time;

  logic              stable_pressed;
  logic [TIME_W-1:0] agree_time;
  logic [TIME_W-1:0] press_time;
  logic              short_fired;
  logic              long_fired;

  logic              pin_down;
  logic              disagree;
  logic [TIME_W-1:0] since;
  logic              flip;
  logic              press_now;
  logic              stable_next;
  logic [TIME_W-1:0] held;
  logic              sf_eff;
  logic              lf_eff;
  logic              short_ev;
  logic              long_ev;
  logic              accept;

  assign in_ready    = ~q_full;
  assign accept      = in_valid & in_ready;

  assign pin_down    = ~pin_level;
  assign disagree    = pin_down != stable_pressed;
  assign since       = now_ms - agree_time;
  assign flip        = disagree && (since >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
  assign press_now   = flip & pin_down;
  assign stable_next = flip ? pin_down : stable_pressed;

  // a fresh press starts the hold clock at this tick
  assign held        = press_now ? '0 : (now_ms - press_time);
  assign sf_eff      = press_now ? 1'b0 : short_fired;
  assign lf_eff      = press_now ? 1'b0 : long_fired;
  assign short_ev    = stable_next && !sf_eff &&
                       (held >= {{(TIME_W-CFG_W){1'b0}}, short_hold_time});
  assign long_ev     = stable_next && !lf_eff &&
                       (held >= {{(TIME_W-CFG_W){1'b0}}, long_hold_time});

  always_comb begin
    push_data                = '0;
    push_data.mask[EV_EDGE]  = flip;
    push_data.mask[EV_SHORT] = short_ev;
    push_data.mask[EV_LONG]  = long_ev;
    push_data.is_release     = ~pin_down;
    push_data.stamp          = now_ms;
  end

  assign push = accept & (flip | short_ev | long_ev);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      short_hold_time <= SHORT_HOLD_RESET;
      long_hold_time  <= LONG_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_time   <= cfg_data;
        REG_SHORT_HOLD: short_hold_time <= cfg_data;
        REG_LONG_HOLD:  long_hold_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_pressed <= 1'b0;
      agree_time     <= '0;
      press_time     <= '0;
      short_fired    <= 1'b0;
      long_fired     <= 1'b0;
    end else if (accept) begin
      stable_pressed <= stable_next;
      // hold agree_time only while a disagreement is still settling
      if (!disagree || flip) begin
        agree_time <= now_ms;
      end
      if (press_now) begin
        press_time <= now_ms;
      end
      short_fired <= sf_eff | short_ev;
      long_fired  <= lf_eff | long_ev;
    end
  end

endmodule

>>> rtl/bdh_queue.sv
// Small FIFO of event sets between the front end and the output sequencer.
module bdh_queue
  import bdh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bdh_evset_t push_data,
  input  logic       pop,
  output logic       q_valid,
  output logic       q_full,
  output bdh_evset_t head
);

  bdh_evset_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_valid = count != '0;
  assign q_full  = count == QCNT_W'(QDEPTH);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/bdh_back.sv
// Output sequencer: unpacks event sets into single events on the result channel.
module bdh_back
  import bdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  bdh_evset_t        head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] event_kind,
  output logic [TIME_W-1:0] event_time,
  output logic              last_event
);

  logic [EV_N-1:0]   pend_mask;
  logic              pend_rel;
  logic [TIME_W-1:0] pend_stamp;

  logic              take;
  logic              have;
  logic              load;
  logic [EV_N-1:0]   src_mask;
  logic              src_rel;
  logic [TIME_W-1:0] src_stamp;
  logic [EV_N-1:0]   rest;
  logic [KIND_W-1:0] kind;

  assign take = ~out_valid | out_ready;
  assign have = pend_mask != '0;
  assign pop  = take & ~have & q_valid;
  assign load = take & (have | q_valid);

  assign src_mask  = have ? pend_mask  : head.mask;
  assign src_rel   = have ? pend_rel   : head.is_release;
  assign src_stamp = have ? pend_stamp : head.stamp;

  // drop the lowest set bit: that is the event going out now
  assign rest = src_mask & (src_mask - 1'b1);

  always_comb begin
    if (src_mask[EV_EDGE]) begin
      kind = src_rel ? KIND_RELEASED : KIND_PRESSED;
    end else if (src_mask[EV_SHORT]) begin
      kind = KIND_SHORT;
    end else begin
      kind = KIND_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_mask <= '0;
    end else if (take) begin
      out_valid <= load;
      if (load) begin
        pend_mask <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_rel   <= src_rel;
      pend_stamp <= src_stamp;
      event_kind <= kind;
      event_time <= src_stamp;
      last_event <= rest == '0;
    end
  end

endmodule

>>> rtl/button_debounce_hold_detector.sv
// Top level of the button debounce and hold detector.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------
//   config   | cfg_we             | cfg_index, cfg_data
//   tick in  | in_valid/in_ready  | pin_level, now_ms
//   event out| out_valid/out_ready| event_kind, event_time, last_event
//
// A tick is taken every cycle while the two-entry event queue has room; the
// front end settles all state for a tick in the cycle it is taken. A set's
// events leave the queue head one at a time through the output register, one
// per cycle while out_ready is high; last_event marks the last of each set.
// Ticks that raise no event never enter the queue. Reset (rst, synchronous)
// restores the register defaults, clears debounce state and empties the path.
module button_debounce_hold_detector
  import bdh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 pin_level,
  input  logic [TIME_W-1:0]    now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    event_kind,
  output logic [TIME_W-1:0]    event_time,
  output logic                 last_event
);

  logic       push;
  logic       pop;
  logic       q_valid;
  logic       q_full;
  bdh_evset_t push_data;
  bdh_evset_t head;

  bdh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pin_level (pin_level),
    .now_ms    (now_ms),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bdh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head)
  );

  bdh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .event_time (event_time),
    .last_event (last_event)
  );

endmodule

>>> rtl/bdh_checker.sv
// Port-level checks for the button debounce and hold detector, with bind.
module bdh_checker
  import bdh_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] event_kind,
  input logic [TIME_W-1:0] event_time,
  input logic              last_event
);

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(event_time) && $stable(last_event))
    else $error("stalled event changed");

  // events of one tick follow back to back with the same timestamp
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_event |=> out_valid && $stable(event_time))
    else $error("event run broken");

  // released and long-hold events always close a tick's run
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_RELEASED || event_kind == KIND_LONG)
      |-> last_event)
    else $error("released or long-hold event not last");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind button_debounce_hold_detector bdh_checker u_bdh_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_kind (event_kind),
  .event_time (event_time),
  .last_event (last_event)
);

>>> tb/sv/button_debounce_hold_detector_checker.sv
// Event predictor and scoreboard for the button debounce and hold detector.
`timescale 1ns / 1ps

module button_debounce_hold_detector_checker
  import bdh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 pin_level,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [KIND_W-1:0]    event_kind,
  input  logic [TIME_W-1:0]    event_time,
  input  logic                 last_event,
  output int                   failures,
  output int                   pending,
  output int                   ticks_seen,
  output int                   events_seen
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } button_event_t;

  localparam int MAX_EVENTS = 3;

  button_event_t expected_events[$];

  logic [CFG_W-1:0]  settle_ms;
  logic [CFG_W-1:0]  short_ms;
  logic [CFG_W-1:0]  long_ms;
  logic              debounced_down;
  logic [TIME_W-1:0] agreed_at;
  logic [TIME_W-1:0] pressed_at;
  logic              short_done;
  logic              long_done;

  // Advance the debounce state by one tick and queue the events it raises.
  task automatic debounce_tick(input logic pin, input logic [TIME_W-1:0] stamp);
    logic              raw_down;
    logic [TIME_W-1:0] elapsed;
    logic [KIND_W-1:0] kinds [MAX_EVENTS];
    button_event_t     ev;
    int                n;
    raw_down = ~pin;
    n = 0;
    if (raw_down != debounced_down) begin
      elapsed = stamp - agreed_at;
      if (elapsed >= TIME_W'(settle_ms)) begin
        debounced_down = raw_down;
        agreed_at = stamp;
        if (raw_down) begin
          pressed_at = stamp;
          short_done = 1'b0;
          long_done = 1'b0;
          kinds[n] = KIND_PRESSED;
        end else begin
          kinds[n] = KIND_RELEASED;
        end
        n++;
      end
    end else begin
      agreed_at = stamp;
    end
    if (debounced_down) begin
      elapsed = stamp - pressed_at;
      if (!short_done && elapsed >= TIME_W'(short_ms)) begin
        short_done = 1'b1;
        kinds[n] = KIND_SHORT;
        n++;
      end
      if (!long_done && elapsed >= TIME_W'(long_ms)) begin
        long_done = 1'b1;
        kinds[n] = KIND_LONG;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      ev.kind = kinds[i];
      ev.stamp = stamp;
      ev.last = (i == n - 1);
      expected_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    button_event_t want;
    if (rst) begin
      settle_ms = DEBOUNCE_RESET;
      short_ms = SHORT_HOLD_RESET;
      long_ms = LONG_HOLD_RESET;
      debounced_down = 1'b0;
      agreed_at = '0;
      pressed_at = '0;
      short_done = 1'b0;
      long_done = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:   settle_ms = cfg_data;
          REG_SHORT_HOLD: short_ms = cfg_data;
          REG_LONG_HOLD:  long_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ticks_seen++;
        debounce_tick(pin_level, now_ms);
      end
      if (out_valid && out_ready) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          failures++;
          $display("%0t: unexpected event: expected none, got kind %0d time %h last %0b",
                   $time, event_kind, event_time, last_event);
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind) begin
            failures++;
            $display("%0t: event_kind mismatch: expected %0d, got %0d",
                     $time, want.kind, event_kind);
          end
          if (event_time !== want.stamp) begin
            failures++;
            $display("%0t: event_time mismatch: expected %h, got %h",
                     $time, want.stamp, event_time);
          end
          if (last_event !== want.last) begin
            failures++;
            $display("%0t: last_event mismatch: expected %0b, got %0b",
                     $time, want.last, last_event);
          end
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

>>> tb/sv/button_debounce_hold_detector_test.sv
// Stimulus, clock, reset and verdict for the button debounce and hold detector.
`timescale 1ns / 1ps

module button_debounce_hold_detector_test;
  import bdh_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 5;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 5;
  localparam int PHASE_TICKS     = 22;

  // index beyond the register list; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 pin_level = 1'b1;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    event_kind;
  logic [TIME_W-1:0]    event_time;
  logic                 last_event;

  int failures;
  int pending;
  int ticks_seen;
  int events_seen;

  int                cycle_count = 0;
  int                ticks_sent = 0;
  int                settings_used = 1;
  int                hold_off_asked = 0;
  logic              quiet_mode = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic [CFG_W-1:0]  cur_db = DEBOUNCE_RESET;
  logic [CFG_W-1:0]  cur_sh = SHORT_HOLD_RESET;
  logic [CFG_W-1:0]  cur_lh = LONG_HOLD_RESET;

  button_debounce_hold_detector i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pin_level  (pin_level),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .event_time (event_time),
    .last_event (last_event)
  );

  button_debounce_hold_detector_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pin_level   (pin_level),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .event_time  (event_time),
    .last_event  (last_event),
    .failures    (failures),
    .pending     (pending),
    .ticks_seen  (ticks_seen),
    .events_seen (events_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events outstanding", $time, pending);
      $display("button_debounce_hold_detector test failed");
      $finish;
    end
  end

  // Mostly no gap, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned bounce_step();
    return $urandom_range(0, cur_db + cur_db / 2 + 1);
  endfunction

  function automatic int unsigned hold_step();
    logic [CFG_W-1:0] top_hold;
    top_hold = (cur_sh > cur_lh) ? cur_sh : cur_lh;
    return $urandom_range(0, top_hold / 2 + 2);
  endfunction

  task automatic send_tick(input logic pin, input logic [TIME_W-1:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pin_level <= pin;
    now_ms <= stamp;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic tick_after(input logic pin, input int unsigned step);
    clock_ms = clock_ms + step;
    send_tick(pin, clock_ms);
  endtask

  // Bounce down, hold across the thresholds, bounce up, settle released.
  task automatic press_cycle();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) begin
      tick_after(1'b0, bounce_step());
      tick_after(1'b1, bounce_step());
    end
    n = $urandom_range(1, 6);
    repeat (n) tick_after(1'b0, hold_step());
    n = $urandom_range(0, 2);
    repeat (n) begin
      tick_after(1'b1, bounce_step());
      tick_after(1'b0, bounce_step());
    end
    n = $urandom_range(1, 3);
    repeat (n) tick_after(1'b1, bounce_step());
  endtask

  // Hold input until every expected event is out and the front end is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] sh,
                              input logic [CFG_W-1:0] lh);
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_SHORT_HOLD, sh);
    write_reg(REG_LONG_HOLD, lh);
    cfg_we <= 1'b0;
    cur_db = db;
    cur_sh = sh;
    cur_lh = lh;
    settings_used++;
  endtask

  initial begin : receiver
    int stall;
    int hold_off_served;
    hold_off_served = 0;
    forever begin
      if (hold_off_served != hold_off_asked) begin
        hold_off_served++;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] db;
    logic [CFG_W-1:0] sh;
    logic [CFG_W-1:0] lh;
    int               target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: debounce edges, both holds, wrap and jump back
    send_tick(1'b1, 32'd0);
    send_tick(1'b0, 32'd5);
    send_tick(1'b0, 32'd20);
    send_tick(1'b0, 32'd1019);
    send_tick(1'b0, 32'd1020);
    send_tick(1'b0, 32'd3020);
    send_tick(1'b1, 32'd3030);
    send_tick(1'b1, 32'd3040);
    send_tick(1'b1, 32'hFFFF_FFF0);
    send_tick(1'b0, 32'h0000_0004);
    send_tick(1'b0, 32'h0000_0000);
    send_tick(1'b1, 32'hFFFF_FFFF);
    drain();

    // zero thresholds: pressed, short and long from one tick
    write_reg(REG_UNUSED, '1);
    apply_config('0, '0, '0);
    send_tick(1'b0, 32'd100);
    send_tick(1'b1, 32'd100);
    send_tick(1'b0, 32'd100);
    send_tick(1'b1, 32'd101);
    drain();

    // long hold below short hold, apart and together
    apply_config(16'd5, 16'd300, 16'd100);
    send_tick(1'b0, 32'd200);
    send_tick(1'b0, 32'd300);
    send_tick(1'b0, 32'd500);
    send_tick(1'b1, 32'd510);
    send_tick(1'b0, 32'd520);
    send_tick(1'b0, 32'd1020);
    drain();

    // largest thresholds, starting from a held button
    apply_config('1, '1, '1);
    send_tick(1'b1, 32'd66054);
    send_tick(1'b1, 32'd66055);
    send_tick(1'b0, 32'd131590);
    send_tick(1'b0, 32'd197125);
    drain();

    clock_ms = 32'd197125;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: begin
          db = CFG_W'($urandom_range(0, 30));
          sh = CFG_W'($urandom_range(0, 600));
          lh = CFG_W'($urandom_range(0, 1500));
        end
        1: begin
          db = CFG_W'($urandom_range(0, 60));
          lh = CFG_W'($urandom_range(0, 800));
          sh = CFG_W'($urandom_range(lh, 2000));
        end
        2: begin
          db = CFG_W'($urandom_range(0, 65535));
          sh = CFG_W'($urandom_range(0, 65535));
          lh = CFG_W'($urandom_range(0, 65535));
        end
        default: begin
          db = CFG_W'($urandom_range(0, 100));
          sh = CFG_W'($urandom_range(0, 3000));
          lh = CFG_W'($urandom_range(sh, 6000));
        end
      endcase
      apply_config(db, sh, lh);
      // stall the event side while ticks keep coming
      if (p == 0) hold_off_asked++;
      quiet_mode = (p == 2);
      target = ticks_sent + PHASE_TICKS;
      while (ticks_sent < target) begin
        if ($urandom_range(0, 99) < 15) begin
          clock_ms = $urandom();
          send_tick(1'($urandom_range(0, 1)), clock_ms);
        end else begin
          press_cycle();
        end
      end
      quiet_mode = 1'b0;
      drain();
    end

    $display("Summary: %0d ticks driven, %0d events checked, %0d register settings.",
             ticks_seen, events_seen, settings_used);
    $display("Summary: zero and full-scale thresholds, long below short, wrap and jump back.");
    if (failures == 0 && pending == 0) begin
      $display("button_debounce_hold_detector test passed");
    end else begin
      $display("button_debounce_hold_detector test failed");
    end
    $finish;
  end

endmodule
